// ----- rtl/ibwt_pkg.sv -----
// Shared types and constants for the inverse BWT block decoder.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ibwt_pkg;

   localparam int LEN_W    = 13;
   localparam int SYM_W    = 9;
   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 12;
   localparam int STATUS_W = 3;
   localparam int OPC_W    = 2;

   localparam int SYM_COUNT = 257;
   localparam int LIMIT_MAX = 8191;

   localparam logic [SYM_W-1:0] END_SYMBOL   = 9'd256;
   localparam logic [LEN_W-1:0] LAST_SYM_IDX = 13'd256;
   localparam logic [LEN_W-1:0] LIMIT_RESET  = 13'd4096;

   localparam logic [STATUS_W-1:0] ST_BYTE      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_READY     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_START = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

   typedef enum logic [OPC_W-1:0] {
      OPC_LOAD   = 2'd0,
      OPC_FINISH = 2'd1,
      OPC_FETCH  = 2'd2,
      OPC_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_LOAD,
      DP_OVERFLOW,
      DP_EMPTY,
      DP_BAD_START,
      DP_BEGIN,
      DP_CLEAR,
      DP_STORE_RD,
      DP_COUNT_RD,
      DP_COUNT_WR,
      DP_PREFIX_RD,
      DP_PREFIX_WR,
      DP_VECTOR_RD,
      DP_VECTOR_WR,
      DP_READY,
      DP_FETCH_RD,
      DP_FETCH_DONE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic overflow;
      logic bad_start;
      logic walk_empty;
      logic byte_last;
      logic sym_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- rtl/ibwt_ctrl.sv -----
// Controller state machine for the inverse BWT block decoder.
// Sequences the datapath through its passes; depends on ibwt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ibwt_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [1:0]             opcode,
   input  wire ibwt_pkg::dp_status_type status,
   output ibwt_pkg::dp_cmd_type        cmd,
   output logic                        busy
);
   import ibwt_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE      = 12'b0000_0000_0001,
      S_CLEAR     = 12'b0000_0000_0010,
      S_CNT_RD    = 12'b0000_0000_0100,
      S_CNT_SYM   = 12'b0000_0000_1000,
      S_CNT_WR    = 12'b0000_0001_0000,
      S_PFX_RD    = 12'b0000_0010_0000,
      S_PFX_WR    = 12'b0000_0100_0000,
      S_VEC_RD    = 12'b0000_1000_0000,
      S_VEC_SYM   = 12'b0001_0000_0000,
      S_VEC_WR    = 12'b0010_0000_0000,
      S_DONE      = 12'b0100_0000_0000,
      S_FETCH_OUT = 12'b1000_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = DP_NOP;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (opcode)
                  OPC_LOAD: begin
                     cmd.op = status.overflow ? DP_OVERFLOW : DP_LOAD;
                  end
                  OPC_FINISH: begin
                     if (status.bad_start) begin
                        cmd.op = DP_BAD_START;
                     end else begin
                        cmd.op   = DP_BEGIN;
                        state_in = S_CLEAR;
                     end
                  end
                  OPC_FETCH: begin
                     if (status.walk_empty) begin
                        cmd.op = DP_EMPTY;
                     end else begin
                        cmd.op   = DP_FETCH_RD;
                        state_in = S_FETCH_OUT;
                     end
                  end
                  default: begin
                     cmd.op = DP_NOP;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            cmd.op = DP_CLEAR;
            if (status.sym_last) begin
               state_in = S_CNT_RD;
            end
         end
         S_CNT_RD: begin
            cmd.op   = DP_STORE_RD;
            state_in = S_CNT_SYM;
         end
         S_CNT_SYM: begin
            cmd.op   = DP_COUNT_RD;
            state_in = S_CNT_WR;
         end
         S_CNT_WR: begin
            cmd.op   = DP_COUNT_WR;
            state_in = status.byte_last ? S_PFX_RD : S_CNT_RD;
         end
         S_PFX_RD: begin
            cmd.op   = DP_PREFIX_RD;
            state_in = S_PFX_WR;
         end
         S_PFX_WR: begin
            cmd.op   = DP_PREFIX_WR;
            state_in = status.sym_last ? S_VEC_RD : S_PFX_RD;
         end
         S_VEC_RD: begin
            cmd.op   = DP_STORE_RD;
            state_in = S_VEC_SYM;
         end
         S_VEC_SYM: begin
            cmd.op   = DP_VECTOR_RD;
            state_in = S_VEC_WR;
         end
         S_VEC_WR: begin
            cmd.op   = DP_VECTOR_WR;
            state_in = status.byte_last ? S_DONE : S_VEC_RD;
         end
         S_DONE: begin
            cmd.op   = DP_READY;
            state_in = S_IDLE;
         end
         S_FETCH_OUT: begin
            cmd.op   = DP_FETCH_DONE;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

// ----- rtl/ibwt_datapath.sv -----
// Datapath of the inverse BWT block decoder: block store, symbol count and
// prefix memories, transformation vector, walk registers and result register.
// Driven by ibwt_ctrl through command and status structs; depends on ibwt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ibwt_datapath #(
   parameter int BLOCK_DEPTH = 4096
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire ibwt_pkg::dp_cmd_type                 cmd,
   output ibwt_pkg::dp_status_type                   status,
   input  wire logic [ibwt_pkg::BYTE_W-1:0]          req_data_byte,
   input  wire logic [ibwt_pkg::INDEX_W-1:0]         req_start_index,
   input  wire logic [ibwt_pkg::INDEX_W-1:0]         req_sentinel_index,
   input  wire logic                                 csr_write_enable,
   input  wire logic [ibwt_pkg::LEN_W-1:0]           csr_write_data,
   output logic                                      rsp_valid,
   output logic [ibwt_pkg::BYTE_W-1:0]               rsp_out_byte,
   output logic                                      rsp_out_last,
   output logic [ibwt_pkg::STATUS_W-1:0]             rsp_status
);
   import ibwt_pkg::*;

   localparam int AW      = $clog2(BLOCK_DEPTH);
   localparam int XW      = (AW > LEN_W) ? AW : LEN_W;
   localparam int CAP     = (BLOCK_DEPTH > LIMIT_MAX) ? LIMIT_MAX : BLOCK_DEPTH;
   localparam logic [LEN_W-1:0] LIMIT_CAP = LEN_W'(CAP);

   logic [BYTE_W-1:0]  store_mem [BLOCK_DEPTH];
   logic [AW-1:0]      vec_mem   [BLOCK_DEPTH];
   logic [LEN_W-1:0]   cnt_mem   [SYM_COUNT];
   logic [LEN_W-1:0]   pfx_mem   [SYM_COUNT];

   logic [LEN_W-1:0]   limit_ff, limit_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   remain_ff, remain_in;
   logic [AW-1:0]      walk_ff, walk_in;
   logic [LEN_W-1:0]   idx_ff, idx_in;
   logic [LEN_W-1:0]   sum_ff, sum_in;
   logic [INDEX_W-1:0] start_ff, start_in;
   logic [INDEX_W-1:0] sentinel_ff, sentinel_in;
   logic [SYM_W-1:0]   sym_ff, sym_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [BYTE_W-1:0]  store_rdata_ff;
   logic [AW-1:0]      vec_rdata_ff;
   logic [LEN_W-1:0]   cnt_rdata_ff;
   logic [LEN_W-1:0]   pfx_rdata_ff;

   logic               store_we, store_re;
   logic [AW-1:0]      store_waddr, store_raddr;
   logic               vec_we, vec_re;
   logic               cnt_we, cnt_re;
   logic [SYM_W-1:0]   cnt_waddr, cnt_raddr;
   logic [LEN_W-1:0]   cnt_wdata;
   logic               pfx_we, pfx_re;

   logic [LEN_W-1:0]   limit_eff;
   logic [LEN_W-1:0]   len_minus_one;
   logic [LEN_W-1:0]   idx_next;
   logic [LEN_W-1:0]   slot_sum;
   logic [XW-1:0]      len_x, idx_x, slot_x, start_x;

   assign limit_eff     = (limit_ff > LIMIT_CAP) ? LIMIT_CAP : limit_ff;
   assign len_minus_one = len_ff - LEN_W'(1);
   assign idx_next      = idx_ff + LEN_W'(1);
   assign slot_sum      = pfx_rdata_ff + cnt_rdata_ff;
   assign len_x         = XW'(len_ff);
   assign idx_x         = XW'(idx_ff);
   assign slot_x        = XW'(slot_sum);
   assign start_x       = XW'(start_ff);

   assign sym_in = (idx_ff == LEN_W'(sentinel_ff)) ? END_SYMBOL : {1'b0, store_rdata_ff};

   assign status.overflow   = (len_ff >= limit_eff);
   assign status.bad_start  = (LEN_W'(req_start_index) >= len_ff);
   assign status.walk_empty = (remain_ff == '0);
   assign status.byte_last  = (idx_ff == len_minus_one);
   assign status.sym_last   = (idx_ff == LAST_SYM_IDX);

   always_comb begin
      limit_in      = csr_write_enable ? csr_write_data : limit_ff;
      len_in        = len_ff;
      remain_in     = remain_ff;
      walk_in       = walk_ff;
      idx_in        = idx_ff;
      sum_in        = sum_ff;
      start_in      = start_ff;
      sentinel_in   = sentinel_ff;
      rsp_valid_in  = 1'b0;
      rsp_byte_in   = '0;
      rsp_last_in   = 1'b0;
      rsp_status_in = ST_BYTE;
      store_we      = 1'b0;
      store_re      = 1'b0;
      store_waddr   = len_x[AW-1:0];
      store_raddr   = idx_x[AW-1:0];
      vec_we        = 1'b0;
      vec_re        = 1'b0;
      cnt_we        = 1'b0;
      cnt_re        = 1'b0;
      cnt_waddr     = idx_ff[SYM_W-1:0];
      cnt_raddr     = idx_ff[SYM_W-1:0];
      cnt_wdata     = '0;
      pfx_we        = 1'b0;
      pfx_re        = 1'b0;
      case (cmd.op)
         DP_LOAD: begin
            store_we = 1'b1;
            len_in   = len_ff + LEN_W'(1);
         end
         DP_OVERFLOW: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OVERFLOW;
         end
         DP_EMPTY: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_EMPTY;
         end
         DP_BAD_START: begin
            len_in        = '0;
            remain_in     = '0;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_BAD_START;
         end
         DP_BEGIN: begin
            start_in    = req_start_index;
            sentinel_in = req_sentinel_index;
            idx_in      = '0;
            sum_in      = '0;
         end
         DP_CLEAR: begin
            cnt_we = 1'b1;
            idx_in = status.sym_last ? '0 : idx_next;
         end
         DP_STORE_RD: begin
            store_re = 1'b1;
         end
         DP_COUNT_RD: begin
            cnt_re    = 1'b1;
            cnt_raddr = sym_in;
         end
         DP_COUNT_WR: begin
            cnt_we    = 1'b1;
            cnt_waddr = sym_ff;
            cnt_wdata = cnt_rdata_ff + LEN_W'(1);
            idx_in    = status.byte_last ? '0 : idx_next;
         end
         DP_PREFIX_RD: begin
            cnt_re = 1'b1;
         end
         DP_PREFIX_WR: begin
            pfx_we = 1'b1;
            cnt_we = 1'b1;
            sum_in = sum_ff + cnt_rdata_ff;
            idx_in = status.sym_last ? '0 : idx_next;
         end
         DP_VECTOR_RD: begin
            cnt_re    = 1'b1;
            cnt_raddr = sym_in;
            pfx_re    = 1'b1;
         end
         DP_VECTOR_WR: begin
            vec_we    = 1'b1;
            cnt_we    = 1'b1;
            cnt_waddr = sym_ff;
            cnt_wdata = cnt_rdata_ff + LEN_W'(1);
            idx_in    = status.byte_last ? '0 : idx_next;
         end
         DP_READY: begin
            walk_in       = start_x[AW-1:0];
            remain_in     = len_minus_one;
            len_in        = '0;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_READY;
         end
         DP_FETCH_RD: begin
            store_re    = 1'b1;
            store_raddr = walk_ff;
            vec_re      = 1'b1;
         end
         DP_FETCH_DONE: begin
            walk_in       = vec_rdata_ff;
            remain_in     = remain_ff - LEN_W'(1);
            rsp_valid_in  = 1'b1;
            rsp_byte_in   = store_rdata_ff;
            rsp_last_in   = (remain_ff == LEN_W'(1));
            rsp_status_in = ST_BYTE;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         len_ff       <= '0;
         remain_ff    <= '0;
         walk_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         len_ff       <= len_in;
         remain_ff    <= remain_in;
         walk_ff      <= walk_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff        <= sum_in;
      start_ff      <= start_in;
      sentinel_ff   <= sentinel_in;
      sym_ff        <= sym_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_waddr] <= req_data_byte;
      end
      if (store_re) begin
         store_rdata_ff <= store_mem[store_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (vec_we) begin
         vec_mem[slot_x[AW-1:0]] <= idx_x[AW-1:0];
      end
      if (vec_re) begin
         vec_rdata_ff <= vec_mem[walk_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (cnt_re) begin
         cnt_rdata_ff <= cnt_mem[cnt_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (pfx_we) begin
         pfx_mem[idx_ff[SYM_W-1:0]] <= sum_ff;
      end
      if (pfx_re) begin
         pfx_rdata_ff <= pfx_mem[sym_in];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

`default_nettype wire

// ----- rtl/inverse_bwt_block_decoder_unit.sv -----
// Top level of the inverse BWT block decoder: controller plus datapath.
// Depends on ibwt_pkg, ibwt_ctrl and ibwt_datapath.
//
// A command transfer happens on a rising edge with start high and busy low.
// Opcode 0 stores a byte, opcode 1 finishes the block, opcode 2 fetches the
// next decoded byte, and opcode 3 is ignored. Each result is shown for one
// cycle with rsp_valid high, in the cycle after the command's last step;
// the receiver cannot stall, so results are never held back.
// A load keeps busy low; an overflowing load, a fetch
// with nothing pending and a bad start give their result the next cycle.
// A fetch first reads the store and vector memories, then gives the result.
// A good finish takes the indices, clears all 257 count memory entries,
// then runs a count pass (per byte: read the store, read and write back the
// count), a prefix pass (per symbol: read the count, write the prefix), and
// a vector pass (per byte: read the store, then count and prefix, write the
// vector) and gives the ready result. The user writes the block limit
// register with csr_write_enable only while idle; the block does not enforce it.
// Reset empties the block, cancels any walk and sets the limit to 4096.
`timescale 1ns / 1ps
`default_nettype none

module inverse_bwt_block_decoder_unit #(
   parameter int BLOCK_DEPTH = 4096
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [ibwt_pkg::OPC_W-1:0]        req_opcode,
   input  wire logic [ibwt_pkg::BYTE_W-1:0]       req_data_byte,
   input  wire logic [ibwt_pkg::INDEX_W-1:0]      req_start_index,
   input  wire logic [ibwt_pkg::INDEX_W-1:0]      req_sentinel_index,
   output logic                                   rsp_valid,
   output logic [ibwt_pkg::BYTE_W-1:0]            rsp_out_byte,
   output logic                                   rsp_out_last,
   output logic [ibwt_pkg::STATUS_W-1:0]          rsp_status,
   input  wire logic                              csr_write_enable,
   input  wire logic [ibwt_pkg::LEN_W-1:0]        csr_write_data
);
   import ibwt_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   ibwt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .opcode (req_opcode),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   ibwt_datapath #(
      .BLOCK_DEPTH (BLOCK_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_data_byte      (req_data_byte),
      .req_start_index    (req_start_index),
      .req_sentinel_index (req_sentinel_index),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_out_last       (rsp_out_last),
      .rsp_status         (rsp_status)
   );

endmodule

`default_nettype wire

// ----- tb/inverse_bwt_block_decoder_unit_checker.sv -----
// Checker for the inverse BWT block decoder: watches the command, result and register ports,
// predicts every result from its own copy of the decoder state and compares it field by field.
// Depends on ibwt_pkg.
`timescale 1ns / 1ps

module inverse_bwt_block_decoder_unit_checker #(
   parameter int BLOCK_DEPTH = 4096
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic                            busy,
   input  wire logic [ibwt_pkg::OPC_W-1:0]      req_opcode,
   input  wire logic [ibwt_pkg::BYTE_W-1:0]     req_data_byte,
   input  wire logic [ibwt_pkg::INDEX_W-1:0]    req_start_index,
   input  wire logic [ibwt_pkg::INDEX_W-1:0]    req_sentinel_index,
   input  wire logic                            rsp_valid,
   input  wire logic [ibwt_pkg::BYTE_W-1:0]     rsp_out_byte,
   input  wire logic                            rsp_out_last,
   input  wire logic [ibwt_pkg::STATUS_W-1:0]   rsp_status,
   input  wire logic                            csr_write_enable,
   input  wire logic [ibwt_pkg::LEN_W-1:0]      csr_write_data,
   output int                                   fail_count,
   output int                                   outstanding
);
   import ibwt_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0]   out_byte;
      logic                out_last;
      logic [STATUS_W-1:0] status;
   } decoded_result_type;

   logic [BYTE_W-1:0]  stored_bytes [BLOCK_DEPTH];
   logic [INDEX_W-1:0] link_table [BLOCK_DEPTH];
   int unsigned        sym_tally [SYM_COUNT];
   int unsigned        sym_base [SYM_COUNT];
   int unsigned        kept_bytes;
   int unsigned        walk_row;
   int unsigned        walk_left;
   int unsigned        limit_reg;
   int                 mismatches;
   decoded_result_type expected_outputs [$];

   function automatic int unsigned symbol_of(input int unsigned pos,
                                             input logic [INDEX_W-1:0] sentinel);
      return (pos == sentinel) ? int'(END_SYMBOL) : int'(stored_bytes[pos]);
   endfunction

   task automatic build_links(input logic [INDEX_W-1:0] sentinel);
      int unsigned running;
      int unsigned sym;
      int unsigned slot;
      running = 0;
      for (int s = 0; s < SYM_COUNT; s++) sym_tally[s] = 0;
      for (int unsigned i = 0; i < kept_bytes; i++) sym_tally[symbol_of(i, sentinel)]++;
      for (int s = 0; s < SYM_COUNT; s++) begin
         sym_base[s] = running;
         running += sym_tally[s];
         sym_tally[s] = 0;
      end
      for (int unsigned i = 0; i < kept_bytes; i++) begin
         sym = symbol_of(i, sentinel);
         slot = sym_base[sym] + sym_tally[sym];
         if (slot < BLOCK_DEPTH) link_table[slot] = INDEX_W'(i);
         sym_tally[sym]++;
      end
   endtask

   task automatic decode_command(input logic [OPC_W-1:0] opc, input logic [BYTE_W-1:0] data_v,
                                 input logic [INDEX_W-1:0] start_v,
                                 input logic [INDEX_W-1:0] sent_v,
                                 output bit produced, output decoded_result_type res);
      int unsigned lim;
      int unsigned pos;
      lim = (limit_reg > BLOCK_DEPTH) ? BLOCK_DEPTH : limit_reg;
      produced = 1'b0;
      res = '{out_byte: '0, out_last: 1'b0, status: ST_BYTE};
      case (opcode_type'(opc))
         OPC_LOAD: begin
            if (kept_bytes >= lim) begin
               produced = 1'b1;
               res.status = ST_OVERFLOW;
            end else begin
               stored_bytes[kept_bytes] = data_v;
               kept_bytes++;
            end
         end
         OPC_FINISH: begin
            produced = 1'b1;
            if (start_v >= kept_bytes) begin
               kept_bytes = 0;
               walk_left = 0;
               res.status = ST_BAD_START;
            end else begin
               build_links(sent_v);
               walk_row = int'(start_v);
               walk_left = kept_bytes - 1;
               kept_bytes = 0;
               res.status = ST_READY;
            end
         end
         OPC_FETCH: begin
            produced = 1'b1;
            if (walk_left == 0) begin
               res.status = ST_EMPTY;
            end else begin
               pos = walk_row % BLOCK_DEPTH;
               res.out_byte = stored_bytes[pos];
               walk_row = int'(link_table[pos]);
               walk_left--;
               res.out_last = (walk_left == 0);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      decoded_result_type want;
      decoded_result_type got;
      bit produced;
      if (reset) begin
         for (int s = 0; s < SYM_COUNT; s++) sym_tally[s] = 0;
         kept_bytes = 0;
         walk_row = 0;
         walk_left = 0;
         limit_reg = int'(LIMIT_RESET);
         mismatches = 0;
         expected_outputs.delete();
      end else begin
         if (csr_write_enable === 1'b1) limit_reg = int'(csr_write_data);
         if (start === 1'b1 && busy === 1'b0) begin
            decode_command(req_opcode, req_data_byte, req_start_index, req_sentinel_index,
                           produced, want);
            if (produced) expected_outputs.push_back(want);
         end
         if (rsp_valid === 1'b1) begin
            got = '{out_byte: rsp_out_byte, out_last: rsp_out_last, status: rsp_status};
            if (expected_outputs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result byte=%02h last=%b status=%0d",
                           $time, got.out_byte, got.out_last, got.status);
            end else begin
               want = expected_outputs.pop_front();
               if (got.out_byte !== want.out_byte || got.out_last !== want.out_last ||
                   got.status !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: expected %02h %b %0d, got %02h %b %0d",
                              $time, want.out_byte, want.out_last, want.status,
                              got.out_byte, got.out_last, got.status);
               end
            end
         end
      end
      fail_count <= mismatches;
      outstanding <= expected_outputs.size();
   end

endmodule

// ----- tb/inverse_bwt_block_decoder_unit_tb.sv -----
// Testbench top for the inverse BWT block decoder: clock, reset, command stimulus and verdict.
// Depends on ibwt_pkg, inverse_bwt_block_decoder_unit and inverse_bwt_block_decoder_unit_checker.
`timescale 1ns / 1ps

module inverse_bwt_block_decoder_unit_tb;
   import ibwt_pkg::*;

   localparam int BLOCK_DEPTH    = 4096;
   localparam int RESET_CYCLES   = 11;
   localparam int ITEM_TARGET    = 1050;
   localparam int WATCHDOG_LIMIT = 60000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 16;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [OPC_W-1:0]    req_opcode = OPC_NONE;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic [INDEX_W-1:0]  req_start_index = '0;
   logic [INDEX_W-1:0]  req_sentinel_index = '0;
   logic                rsp_valid;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_out_last;
   logic [STATUS_W-1:0] rsp_status;
   logic                csr_write_enable = 1'b0;
   logic [LEN_W-1:0]    csr_write_data = '0;

   int fail_count;
   int outstanding;
   int idle_cycles = 0;
   int items_sent = 0;
   int kept_len = 0;
   int cur_limit = int'(LIMIT_RESET);
   bit no_idle = 1'b0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   inverse_bwt_block_decoder_unit #(
      .BLOCK_DEPTH(BLOCK_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_data_byte(req_data_byte),
      .req_start_index(req_start_index),
      .req_sentinel_index(req_sentinel_index),
      .rsp_valid(rsp_valid),
      .rsp_out_byte(rsp_out_byte),
      .rsp_out_last(rsp_out_last),
      .rsp_status(rsp_status),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   inverse_bwt_block_decoder_unit_checker #(
      .BLOCK_DEPTH(BLOCK_DEPTH)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_data_byte(req_data_byte),
      .req_start_index(req_start_index),
      .req_sentinel_index(req_sentinel_index),
      .rsp_valid(rsp_valid),
      .rsp_out_byte(rsp_out_byte),
      .rsp_out_last(rsp_out_last),
      .rsp_status(rsp_status),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .fail_count(fail_count),
      .outstanding(outstanding)
   );

   // The watchdog restarts on every command or result transfer.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("inverse_bwt_block_decoder_unit: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 80);
   endfunction

   function automatic int pick_block_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 24);
      if (r < 96) return $urandom_range(25, 160);
      return $urandom_range(161, 700);
   endfunction

   // A block near the end is shortened so the run stays close to its item count.
   function automatic int clip_len(input int want);
      int room;
      room = (ITEM_TARGET - items_sent) / 2;
      if (room < 1) room = 1;
      return (want < room) ? want : room;
   endfunction

   task automatic send_command(input opcode_type opc, input logic [BYTE_W-1:0] data_v,
                               input logic [INDEX_W-1:0] start_v,
                               input logic [INDEX_W-1:0] sent_v);
      int gap;
      int lim;
      gap = pick_gap();
      lim = (cur_limit > BLOCK_DEPTH) ? BLOCK_DEPTH : cur_limit;
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_opcode <= opc;
      req_data_byte <= data_v;
      req_start_index <= start_v;
      req_sentinel_index <= sent_v;
      do @(posedge clock); while (busy !== 1'b0);
      if (opc != OPC_NONE) items_sent++;
      if (opc == OPC_LOAD && kept_len < lim) kept_len++;
      if (opc == OPC_FINISH) kept_len = 0;
   endtask

   task automatic write_limit(input logic [LEN_W-1:0] value);
      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      // A load gives no result, so the last one may still be in flight.
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cur_limit = int'(value);
   endtask

   task automatic run_block(input int req_len);
      int kept;
      int fetches;
      logic [INDEX_W-1:0] start_v;
      logic [INDEX_W-1:0] sent_v;
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < req_len; i++) begin
         send_command(OPC_LOAD, BYTE_W'($urandom), INDEX_W'($urandom), INDEX_W'($urandom));
         if ($urandom_range(0, 39) == 0)
            send_command(OPC_NONE, BYTE_W'($urandom), INDEX_W'($urandom),
                         INDEX_W'($urandom));
      end
      kept = kept_len;
      if (kept == 0 || $urandom_range(0, 11) == 0) start_v = INDEX_W'($urandom);
      else start_v = INDEX_W'($urandom_range(0, kept - 1));
      if (kept == 0 || $urandom_range(0, 7) == 0) sent_v = INDEX_W'($urandom);
      else sent_v = INDEX_W'($urandom_range(0, kept - 1));
      send_command(OPC_FINISH, BYTE_W'($urandom), start_v, sent_v);
      if (start_v < kept) begin
         fetches = kept - 1;
         case ($urandom_range(0, 9))
            0: fetches = $urandom_range(0, kept - 1);
            1, 2: fetches += $urandom_range(1, 2);
            default: ;
         endcase
      end else begin
         fetches = $urandom_range(0, 1);
      end
      for (int i = 0; i < fetches; i++)
         send_command(OPC_FETCH, BYTE_W'($urandom), INDEX_W'($urandom), INDEX_W'($urandom));
   endtask

   initial begin
      int phase;
      logic [LEN_W-1:0] lim;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_command(OPC_FETCH, 8'h00, 12'h000, 12'h000);
      send_command(OPC_FINISH, 8'h00, 12'h000, 12'h000);
      send_command(OPC_NONE, 8'hFF, 12'hFFF, 12'hFFF);
      send_command(OPC_LOAD, 8'h00, 12'h000, 12'h000);
      send_command(OPC_LOAD, 8'hFF, 12'hFFF, 12'hFFF);
      send_command(OPC_LOAD, 8'hA5, 12'hA5A, 12'h5A5);
      send_command(OPC_LOAD, 8'h5A, 12'h5A5, 12'hA5A);
      send_command(OPC_FINISH, 8'h00, 12'd3, 12'd1);
      repeat (4) send_command(OPC_FETCH, 8'h00, 12'h000, 12'h000);
      // A one-byte block is ready but yields nothing.
      send_command(OPC_LOAD, 8'h7E, 12'h000, 12'h000);
      send_command(OPC_FINISH, 8'h00, 12'd0, 12'd0);
      send_command(OPC_FETCH, 8'h00, 12'h000, 12'h000);
      send_command(OPC_LOAD, 8'h11, 12'h000, 12'h000);
      send_command(OPC_LOAD, 8'h22, 12'h000, 12'h000);
      send_command(OPC_FINISH, 8'h00, 12'hFFF, 12'hFFF);
      send_command(OPC_LOAD, 8'h33, 12'h000, 12'h000);
      send_command(OPC_LOAD, 8'h44, 12'h000, 12'h000);
      send_command(OPC_LOAD, 8'h55, 12'h000, 12'h000);
      send_command(OPC_FINISH, 8'h00, 12'd2, 12'hFFF);
      send_command(OPC_FETCH, 8'h00, 12'h000, 12'h000);
      // This load overwrites the store while the walk is still pending.
      send_command(OPC_LOAD, 8'hC3, 12'h000, 12'h000);
      send_command(OPC_FETCH, 8'h00, 12'h000, 12'h000);
      send_command(OPC_FETCH, 8'h00, 12'h000, 12'h000);

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         case (phase)
            0: lim = 13'd2;
            1: lim = LEN_W'(LIMIT_MAX);
            2: lim = LIMIT_RESET;
            default: begin
               case ($urandom_range(0, 3))
                  0, 1: lim = LEN_W'($urandom_range(2, 40));
                  2: lim = LEN_W'($urandom_range(41, LIMIT_MAX));
                  default: lim = LIMIT_RESET;
               endcase
            end
         endcase
         write_limit(lim);
         for (int b = 0; b < 3 && items_sent < ITEM_TARGET; b++)
            run_block(clip_len(pick_block_len()));
         phase++;
      end

      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("inverse_bwt_block_decoder_unit: match");
      end else begin
         $display("inverse_bwt_block_decoder_unit: mismatch");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/ibwt_pkg.sv
rtl/ibwt_ctrl.sv
rtl/ibwt_datapath.sv
rtl/inverse_bwt_block_decoder_unit.sv
tb/inverse_bwt_block_decoder_unit_checker.sv
tb/inverse_bwt_block_decoder_unit_tb.sv
